// ===== hdl/sha256_pkg.sv =====
package sha256_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0]  byte_t;
    typedef logic [5:0]  fill_t;
    typedef logic [5:0]  round_t;
    typedef logic [2:0]  widx_t;
    typedef logic [60:0] count_t;

    localparam int NUM_WORDS = 8;

    localparam fill_t  FILL_LAST      = 6'd63;
    localparam fill_t  FILL_LEN_START = 6'd56;
    localparam round_t LAST_ROUND     = 6'd63;
    localparam widx_t  LAST_WORD_IDX  = 3'd7;
    localparam byte_t  PAD_MARK       = 8'h80;

    localparam word_t INIT_HASH [NUM_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_COMPRESS,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        BYTE_DATA,
        BYTE_MARK,
        BYTE_ZERO,
        BYTE_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      shift_en;
        byte_sel_t byte_sel;
        logic      count_inc;
        logic      load_work;
        logic      round_en;
        logic      fold;
        logic      word_adv;
        logic      restart;
    } cmd_t;

    typedef struct packed {
        fill_t fill;
        logic  round_last;
        logic  word_last;
    } status_t;

    function automatic word_t rotr(input word_t v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ===== hdl/sha256_if.sv =====
interface sha256_msg_if;
    logic                valid;
    logic                ready;
    sha256_pkg::byte_t   data_byte;
    logic                byte_present;
    logic                end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_digest_if;
    logic                valid;
    logic                ready;
    sha256_pkg::word_t   digest_word;
    sha256_pkg::widx_t   word_index;
    logic                last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hdl/sha256_ctrl.sv =====
module sha256_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    input  logic                byte_present,
    input  logic                end_of_message,
    output logic                msg_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  sha256_pkg::status_t status,
    output sha256_pkg::cmd_t    cmd
);

    sha256_pkg::state_t state_reg;
    sha256_pkg::state_t state_next;
    sha256_pkg::state_t resume_reg;
    sha256_pkg::state_t resume_next;

    logic fill_last;
    logic fill_len_start;

    assign fill_last      = (status.fill == sha256_pkg::FILL_LAST);
    assign fill_len_start = (status.fill == sha256_pkg::FILL_LEN_START);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha256_pkg::ST_ACCEPT;
            resume_reg <= sha256_pkg::ST_ACCEPT;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
        end
    end

    // next state; a byte that fills the block detours through compression
    always_comb
    begin
        sha256_pkg::state_t after_st;
        after_st    = end_of_message ? sha256_pkg::ST_PAD_MARK : sha256_pkg::ST_ACCEPT;
        state_next  = state_reg;
        resume_next = resume_reg;
        unique case (state_reg)
            sha256_pkg::ST_ACCEPT:
            begin
                if (msg_valid)
                begin
                    if (byte_present && fill_last)
                    begin
                        state_next  = sha256_pkg::ST_COMPRESS;
                        resume_next = after_st;
                    end
                    else
                    begin
                        state_next = after_st;
                    end
                end
            end
            sha256_pkg::ST_PAD_MARK:
            begin
                if (fill_last)
                begin
                    state_next  = sha256_pkg::ST_COMPRESS;
                    resume_next = sha256_pkg::ST_PAD_ZERO;
                end
                else
                begin
                    state_next = sha256_pkg::ST_PAD_ZERO;
                end
            end
            sha256_pkg::ST_PAD_ZERO:
            begin
                if (fill_len_start)
                begin
                    state_next = sha256_pkg::ST_PAD_LEN;
                end
                else if (fill_last)
                begin
                    state_next  = sha256_pkg::ST_COMPRESS;
                    resume_next = sha256_pkg::ST_PAD_ZERO;
                end
            end
            sha256_pkg::ST_PAD_LEN:
            begin
                if (fill_last)
                begin
                    state_next  = sha256_pkg::ST_COMPRESS;
                    resume_next = sha256_pkg::ST_EMIT;
                end
            end
            sha256_pkg::ST_COMPRESS:
            begin
                if (status.round_last)
                begin
                    state_next = sha256_pkg::ST_FOLD;
                end
            end
            sha256_pkg::ST_FOLD:
            begin
                state_next = resume_reg;
            end
            sha256_pkg::ST_EMIT:
            begin
                if (out_ready && status.word_last)
                begin
                    state_next = sha256_pkg::ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = sha256_pkg::ST_ACCEPT;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.byte_sel = sha256_pkg::BYTE_DATA;
        msg_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            sha256_pkg::ST_ACCEPT:
            begin
                msg_ready = 1'b1;
                if (msg_valid && byte_present)
                begin
                    cmd.shift_en  = 1'b1;
                    cmd.count_inc = 1'b1;
                end
            end
            sha256_pkg::ST_PAD_MARK:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = sha256_pkg::BYTE_MARK;
            end
            sha256_pkg::ST_PAD_ZERO:
            begin
                cmd.shift_en = !fill_len_start;
                cmd.byte_sel = sha256_pkg::BYTE_ZERO;
            end
            sha256_pkg::ST_PAD_LEN:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = sha256_pkg::BYTE_LEN;
            end
            sha256_pkg::ST_COMPRESS:
            begin
                cmd.round_en = 1'b1;
            end
            sha256_pkg::ST_FOLD:
            begin
                cmd.fold = 1'b1;
            end
            sha256_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.word_adv = 1'b1;
                    cmd.restart  = status.word_last;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
        // the 64th byte of a block also loads the working variables
        cmd.load_work = cmd.shift_en && fill_last;
    end

endmodule

// ===== hdl/sha256_datapath.sv =====
module sha256_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sha256_pkg::cmd_t    cmd,
    input  sha256_pkg::byte_t   data_byte,
    output sha256_pkg::status_t status,
    output sha256_pkg::word_t   digest_word,
    output sha256_pkg::widx_t   word_index,
    output logic                last_word
);

    // block bytes, first byte at the top; during rounds the same line
    // is the 16-word schedule window with w[i] in the top word
    logic [511:0]      blk_reg;
    logic [511:0]      blk_next;
    sha256_pkg::word_t work_reg  [sha256_pkg::NUM_WORDS];
    sha256_pkg::word_t work_next [sha256_pkg::NUM_WORDS];
    sha256_pkg::word_t chain_reg [sha256_pkg::NUM_WORDS];
    sha256_pkg::count_t count_reg;
    sha256_pkg::fill_t  fill_reg;
    sha256_pkg::round_t round_reg;
    sha256_pkg::widx_t  word_reg;

    sha256_pkg::byte_t byte_in;
    logic [63:0]       len_bits;
    sha256_pkg::word_t w0;
    sha256_pkg::word_t w1;
    sha256_pkg::word_t w9;
    sha256_pkg::word_t w14;
    sha256_pkg::word_t w_new;
    sha256_pkg::word_t t1;
    sha256_pkg::word_t t2;

    assign len_bits = {count_reg, 3'b000};

    always_comb
    begin
        unique case (cmd.byte_sel)
            sha256_pkg::BYTE_DATA: byte_in = data_byte;
            sha256_pkg::BYTE_MARK: byte_in = sha256_pkg::PAD_MARK;
            sha256_pkg::BYTE_ZERO: byte_in = '0;
            sha256_pkg::BYTE_LEN:  byte_in = len_bits[{~fill_reg[2:0], 3'b000} +: 8];
            default:               byte_in = '0;
        endcase
    end

    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];
    assign w_new = w0 + sha256_pkg::small_sigma0(w1) + w9 + sha256_pkg::small_sigma1(w14);

    assign t1 = work_reg[7] + sha256_pkg::big_sigma1(work_reg[4])
              + sha256_pkg::choose(work_reg[4], work_reg[5], work_reg[6])
              + sha256_pkg::ROUND_K[round_reg] + w0;
    assign t2 = sha256_pkg::big_sigma0(work_reg[0])
              + sha256_pkg::majority(work_reg[0], work_reg[1], work_reg[2]);

    always_comb
    begin
        work_next[0] = t1 + t2;
        work_next[1] = work_reg[0];
        work_next[2] = work_reg[1];
        work_next[3] = work_reg[2];
        work_next[4] = work_reg[3] + t1;
        work_next[5] = work_reg[4];
        work_next[6] = work_reg[5];
        work_next[7] = work_reg[6];
    end

    always_comb
    begin
        blk_next = blk_reg;
        if (cmd.shift_en)
        begin
            blk_next = {blk_reg[503:0], byte_in};
        end
        else if (cmd.round_en)
        begin
            blk_next = {blk_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        for (int i = 0; i < sha256_pkg::NUM_WORDS; i++)
        begin
            if (cmd.load_work)
            begin
                work_reg[i] <= chain_reg[i];
            end
            else if (cmd.round_en)
            begin
                work_reg[i] <= work_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
            round_reg <= '0;
            word_reg  <= '0;
            for (int i = 0; i < sha256_pkg::NUM_WORDS; i++)
            begin
                chain_reg[i] <= sha256_pkg::INIT_HASH[i];
            end
        end
        else
        begin
            if (cmd.shift_en)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.restart)
            begin
                count_reg <= '0;
            end
            else if (cmd.count_inc)
            begin
                count_reg <= count_reg + 61'd1;
            end
            if (cmd.load_work)
            begin
                round_reg <= '0;
            end
            else if (cmd.round_en)
            begin
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.word_adv)
            begin
                word_reg <= word_reg + 3'd1;
            end
            for (int i = 0; i < sha256_pkg::NUM_WORDS; i++)
            begin
                if (cmd.restart)
                begin
                    chain_reg[i] <= sha256_pkg::INIT_HASH[i];
                end
                else if (cmd.fold)
                begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
        end
    end

    assign status.fill       = fill_reg;
    assign status.round_last = (round_reg == sha256_pkg::LAST_ROUND);
    assign status.word_last  = (word_reg == sha256_pkg::LAST_WORD_IDX);

    assign digest_word = chain_reg[word_reg];
    assign word_index  = word_reg;
    assign last_word   = (word_reg == sha256_pkg::LAST_WORD_IDX);

endmodule

// ===== hdl/sha256_byte_stream_hasher_core.sv =====
// SHA-256 hasher over a byte stream.
//
// msg (sink): one transfer per item. byte_present marks data_byte as a
//   message byte; end_of_message closes the message after that byte. An item
//   with end_of_message and no byte closes the message as is (empty message
//   if nothing came before). An item with neither flag is a no-op.
// digest (source): eight transfers per message, word_index 0..7, most
//   significant word first, last_word on index 7.
//
// Timing: a byte that neither completes a block nor ends the message is
// taken with msg.ready staying high. The 64th byte of a block starts
// compression: 64 rounds plus one fold step, msg.ready low throughout.
// The round unit, one round per cycle, sets the rate over long messages.
// After an end item, padding shifts one byte per cycle (plus one or two
// compressions), then the digest is shown. While digest words are pending
// msg.ready stays low; a stalled receiver simply holds the current word,
// nothing is lost. After the eighth word the chaining words and byte count
// return to their start values.
// Reset: chaining words to the initial hash, byte count and fill to zero.
module sha256_byte_stream_hasher_core (
    input  logic         clk,
    input  logic         rst_n,
    sha256_msg_if.sink   msg,
    sha256_digest_if.source digest
);

    sha256_pkg::cmd_t    cmd;
    sha256_pkg::status_t status;

    // sequencing: intake, padding, rounds, digest readout
    sha256_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg.valid),
        .byte_present   (msg.byte_present),
        .end_of_message (msg.end_of_message),
        .msg_ready      (msg.ready),
        .out_valid      (digest.valid),
        .out_ready      (digest.ready),
        .status         (status),
        .cmd            (cmd)
    );

    // block line, round unit, chaining words, counters
    sha256_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (msg.data_byte),
        .status      (status),
        .digest_word (digest.digest_word),
        .word_index  (digest.word_index),
        .last_word   (digest.last_word)
    );

endmodule

// ===== hdl/sha256_checker.sv =====
module sha256_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              msg_ready,
    input logic              out_valid,
    input logic              out_ready,
    input sha256_pkg::word_t digest_word,
    input sha256_pkg::widx_t word_index,
    input logic              last_word
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
        else $error("digest word changed while stalled");

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word
        |=> out_valid && (word_index == 3'($past(word_index) + 3'd1)))
        else $error("digest words not consecutive");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_word |=> !out_valid)
        else $error("digest continues past last word");

    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (word_index == 3'd0))
        else $error("digest does not start at word zero");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !msg_ready)
        else $error("input taken while digest pending");

endmodule

bind sha256_byte_stream_hasher_core sha256_checker u_sha256_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .msg_ready   (msg.ready),
    .out_valid   (digest.valid),
    .out_ready   (digest.ready),
    .digest_word (digest.digest_word),
    .word_index  (digest.word_index),
    .last_word   (digest.last_word)
);

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Round constants and start value of the chain, kept locally so that the
    // expected digests do not lean on the tables inside the design.
    localparam logic [31:0] RND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam sha256_pkg::byte_t PAD_BYTE   = 8'h80;
    localparam int                LEN_OFFSET = 56;
    localparam int                BLOCK_SIZE = 64;

    // Target number of message transfers, no-op items included.
    localparam int TOTAL_ITEMS = 470;
    // Past this many items both sides run without idling.
    localparam int CALM_AFTER  = 400;

    // One expected digest word, as it should appear on the digest channel.
    typedef struct packed {
        sha256_pkg::word_t word;
        sha256_pkg::widx_t idx;
        logic              last;
    } digest_beat_t;

    // Running SHA-256 state for the message in flight plus the queue of digest
    // words still owed by the design.
    class sha256_digest_tracker;
        sha256_pkg::word_t  chain [8];
        sha256_pkg::count_t msg_bytes;
        sha256_pkg::byte_t  blk [BLOCK_SIZE];
        int                 fill;
        digest_beat_t       owed_words [$];
        int                 errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++)
                chain[i] = IV[i];
            msg_bytes = '0;
            fill = 0;
        endfunction

        function sha256_pkg::word_t ror32(sha256_pkg::word_t v, int n);
            return (v >> n) | (v << (32 - n));
        endfunction

        function void compress_block();
            sha256_pkg::word_t w [64];
            sha256_pkg::word_t a, b, c, d, e, f, g, h, t1, t2, s0, s1;
            int i;
            for (i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (i = 16; i < 64; i++)
            begin
                s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
            for (i = 0; i < 64; i++)
            begin
                t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
                       + ((e & f) ^ (~e & g)) + RND_K[i] + w[i];
                t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
                       + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
            chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
        endfunction

        function void push_byte(sha256_pkg::byte_t v);
            blk[fill] = v;
            fill++;
            if (fill == BLOCK_SIZE)
            begin
                compress_block();
                fill = 0;
            end
        endfunction

        // Called once per accepted message transfer.
        function void absorb_item(sha256_pkg::byte_t b, logic present, logic eom);
            logic [63:0] bit_len;
            if (present)
            begin
                push_byte(b);
                msg_bytes = msg_bytes + 1'b1;
            end
            if (!eom)
                return;
            bit_len = {msg_bytes, 3'b000};
            push_byte(PAD_BYTE);
            while (fill != LEN_OFFSET)
                push_byte(8'h00);
            for (int i = 0; i < 8; i++)
                push_byte(bit_len[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++)
                owed_words.push_back('{word: chain[i], idx: sha256_pkg::widx_t'(i),
                                       last: (i == 7)});
            restart();
        endfunction

        // Called once per accepted digest transfer.
        function void match_word(sha256_pkg::word_t w, sha256_pkg::widx_t idx, logic last);
            digest_beat_t exp_beat;
            if (owed_words.size() == 0)
            begin
                $display("%0t: unexpected digest word %h idx %0d last %0b",
                         $time, w, idx, last);
                errors++;
                return;
            end
            exp_beat = owed_words.pop_front();
            if (w !== exp_beat.word)
            begin
                $display("%0t: digest_word expected %h actual %h",
                         $time, exp_beat.word, w);
                errors++;
            end
            if (idx !== exp_beat.idx)
            begin
                $display("%0t: word_index expected %0d actual %0d",
                         $time, exp_beat.idx, idx);
                errors++;
            end
            if (last !== exp_beat.last)
            begin
                $display("%0t: last_word expected %0b actual %0b",
                         $time, exp_beat.last, last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    int   items_sent;

    sha256_digest_tracker tracker;

    sha256_msg_if    msg_if ();
    sha256_digest_if dig_if ();

    sha256_byte_stream_hasher_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_if),
        .digest (dig_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop. The slowest legal run (every item an end item behind the
    // longest valid gap, each followed by padding and compression, and eight
    // digest words each behind the longest stall) stays well below the stop.
    initial
    begin
        #12_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Drive one item and wait for its transfer. Before the item the source may
    // drop valid for a random burst, except in the calm tail.
    task automatic send_item(input sha256_pkg::byte_t b, input logic present,
                             input logic eom);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            msg_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        msg_if.valid          <= 1'b1;
        msg_if.data_byte      <= b;
        msg_if.byte_present   <= present;
        msg_if.end_of_message <= eom;
        @(posedge clk);
        while (!msg_if.ready)
            @(posedge clk);
        // Transfer happened at this edge: ready was seen high with valid up.
        tracker.absorb_item(b, present, eom);
        items_sent++;
        if (items_sent >= CALM_AFTER)
            calm = 1'b1;
    endtask

    // A whole message of random bytes. No-op items are sprinkled in, and the
    // end flag either rides on the final byte or comes as a byte-less item.
    task automatic send_message(input int len);
        sha256_pkg::byte_t b;
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_item(sha256_pkg::byte_t'($urandom), 1'b0, 1'b0);
            b = sha256_pkg::byte_t'($urandom);
            if (k == len - 1 && $urandom_range(0, 1) == 1)
            begin
                send_item(b, 1'b1, 1'b1);
                return;
            end
            send_item(b, 1'b1, 1'b0);
        end
        send_item(sha256_pkg::byte_t'($urandom), 1'b0, 1'b1);
    endtask

    // Message length: mostly short, some medium, a few long ones with extra
    // weight on the lengths where the padding spills into another block.
    function automatic int pick_length();
        int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return $urandom_range(0, 8);
        if (roll < 85)
            return $urandom_range(9, 40);
        if (roll < 93)
            return edges[$urandom_range(0, 9)];
        return $urandom_range(50, 130);
    endfunction

    // Digest side: check every transfer and stall ready in random bursts.
    initial
    begin
        int stall;
        stall = 0;
        dig_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && dig_if.valid && dig_if.ready)
                tracker.match_word(dig_if.digest_word, dig_if.word_index, dig_if.last_word);
            if (stall > 0)
            begin
                stall--;
                dig_if.ready <= (stall == 0);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 17);
                dig_if.ready <= 1'b0;
            end
            else
                dig_if.ready <= 1'b1;
        end
    end

    initial
    begin
        int next_len;
        tracker    = new();
        calm       = 1'b0;
        items_sent = 0;

        rst_n                 <= 1'b0;
        msg_if.valid          <= 1'b0;
        msg_if.data_byte      <= 8'h00;
        msg_if.byte_present   <= 1'b0;
        msg_if.end_of_message <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // empty message: end item with no byte, junk on data_byte
        send_item(8'hff, 1'b0, 1'b1);
        // no-op item right after a digest, must change nothing
        send_item(8'ha5, 1'b0, 1'b0);
        // one-byte message, byte and end in the same transfer
        send_item(8'h00, 1'b1, 1'b1);
        // byte extremes, a no-op in the middle, end as a separate item
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // "abc", end flag riding on the last byte
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // two empty messages back to back
        send_item(8'h80, 1'b0, 1'b1);
        send_item(8'h7f, 1'b0, 1'b1);

        // --- random messages ---
        // the last message is cut short so the total lands near the target
        while (items_sent < TOTAL_ITEMS)
        begin
            next_len = pick_length();
            if (next_len > TOTAL_ITEMS - items_sent)
                next_len = TOTAL_ITEMS - items_sent;
            send_message(next_len);
        end
        msg_if.valid <= 1'b0;

        // Drain, then linger past the worst padding latency for stray words.
        while (tracker.owed_words.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);

        if (tracker.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
